>>> src/llr_pkg.sv
package llr_pkg;

  // Item kinds on the input channel.
  typedef enum logic [1:0] {
    KIND_TABLE = 2'd0,
    KIND_RULE  = 2'd1,
    KIND_CHAR  = 2'd2,
    KIND_END   = 2'd3
  } kind_e;

  // Verdict codes, also used for the sticky failure code.
  typedef enum logic [1:0] {
    VERDICT_ACCEPT   = 2'd0,
    VERDICT_REJECT   = 2'd1,
    VERDICT_OVERFLOW = 2'd2,
    VERDICT_UNUSED   = 2'd3
  } verdict_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OPEN0,
    ST_OPEN1,
    ST_FETCH,
    ST_TOP,
    ST_CELL,
    ST_LEN,
    ST_PUSH,
    ST_VERDICT
  } state_e;

  // Symbol codes.
  localparam logic [7:0] END_MARK = 8'h24;
  localparam logic [7:0] NT_FIRST = 8'h41;
  localparam logic [7:0] NT_LAST  = 8'h5A;

  // Parse table geometry: 26 nonterminal rows by 256 lookahead columns.
  localparam int NT_ROWS   = 26;
  localparam int TBL_DEPTH = NT_ROWS * 256;
  localparam int TBL_AW    = $clog2(TBL_DEPTH);
  localparam int CELL_W    = 7;

  // Reset value of the start symbol register.
  localparam logic [6:0] START_RESET = 7'd83;

endpackage

>>> src/llr_ram.sv
module llr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AddrW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // One write port and one read port; read data is registered and appears in the cycle after the address.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> src/ll1_table_driven_recognizer_top.sv
// LL(1) table-driven recognizer. Table beats (kind 0) and rule beats (kind 1) load
// the parse table and the rule store directly. Character beats (kind 2)
// and end beats (kind 3) run the parse sequencer, which holds the symbol stack in a
// memory: each lookahead beat is accepted, the stack top is read and then matched,
// and every expansion on the way reads the table cell, then the rule length, then
// pushes the symbols, since each step waits on one registered read of the stack, the
// parse table, the rule length store or the rule symbol store. Opening a string first
// writes the end marker and the start symbol, and the verdict is registered once the
// output register is free. After reset the parse table is swept to empty, during
// which no beat is accepted; writes to the start symbol register are taken at any time.
module ll1_table_driven_recognizer_top #(
  parameter int STACK_DEPTH = 64,
  parameter int RULE_COUNT  = 64,
  parameter int RULE_LEN    = 8
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Configuration.
  input  logic       cfg_we_i,
  input  logic [6:0] cfg_wdata_i,
  // Input channel.
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] kind_i,
  input  logic [4:0] nonterminal_index_i,
  input  logic [7:0] table_column_i,
  input  logic [6:0] table_rule_i,
  input  logic [5:0] rule_number_i,
  input  logic [2:0] rule_slot_i,
  input  logic [7:0] rule_symbol_i,
  input  logic [3:0] rule_length_i,
  input  logic [7:0] char_in_i,
  // Output channel.
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] verdict_o
);

  import llr_pkg::*;

  localparam int CntW      = $clog2(STACK_DEPTH + 1);
  localparam int StkAw     = $clog2(STACK_DEPTH);
  localparam int RuleW     = $clog2(RULE_COUNT);
  localparam int LenW      = $clog2(RULE_LEN + 1);
  localparam int RsymDepth = RULE_COUNT * RULE_LEN;
  localparam int RsymAw    = $clog2(RsymDepth);
  localparam int ExpLimit  = (STACK_DEPTH + 1) * 27;
  localparam int StepW     = $clog2(ExpLimit + 1);

  // Registers.
  state_e             state_q, state_d;
  logic [6:0]         start_q;
  logic               open_q, open_d;
  verdict_e           fail_q, fail_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [StepW-1:0]   steps_q, steps_d;
  logic [7:0]         sym_q, sym_d;
  logic               end_q, end_d;
  logic [RsymAw-1:0]  rbase_q, rbase_d;
  logic [LenW-1:0]    k_q, k_d;
  logic [TBL_AW-1:0]  clr_q, clr_d;
  logic               out_valid_q, out_valid_d;
  verdict_e           verdict_q, verdict_d;

  // Memory ports.
  logic               tbl_we;
  logic [TBL_AW-1:0]  tbl_waddr, tbl_raddr;
  logic [CELL_W-1:0]  tbl_wdata, tbl_rdata;
  logic               rsym_we;
  logic [RsymAw-1:0]  rsym_waddr, rsym_raddr;
  logic [7:0]         rsym_rdata;
  logic               rlen_we;
  logic [RuleW-1:0]   rlen_waddr, rlen_raddr;
  logic [LenW-1:0]    rlen_wdata, rlen_rdata;
  logic               stk_we;
  logic [StkAw-1:0]   stk_waddr, stk_raddr;
  logic [7:0]         stk_wdata, stk_rdata;

  // Helpers.
  logic               in_accept;
  logic               out_free;
  logic               is_nt;
  logic [RuleW-1:0]   rule_idx;
  logic [CntW-1:0]    cnt_dec;
  state_e             fin_state;
  verdict_e           end_verdict;

  llr_ram #(.WIDTH(CELL_W), .DEPTH(TBL_DEPTH)) u_table (
    .clk_i   (clk_i),
    .we_i    (tbl_we),
    .waddr_i (tbl_waddr),
    .wdata_i (tbl_wdata),
    .raddr_i (tbl_raddr),
    .rdata_o (tbl_rdata)
  );

  llr_ram #(.WIDTH(8), .DEPTH(RsymDepth)) u_rule_sym (
    .clk_i   (clk_i),
    .we_i    (rsym_we),
    .waddr_i (rsym_waddr),
    .wdata_i (rule_symbol_i),
    .raddr_i (rsym_raddr),
    .rdata_o (rsym_rdata)
  );

  llr_ram #(.WIDTH(LenW), .DEPTH(RULE_COUNT)) u_rule_len (
    .clk_i   (clk_i),
    .we_i    (rlen_we),
    .waddr_i (rlen_waddr),
    .wdata_i (rlen_wdata),
    .raddr_i (rlen_raddr),
    .rdata_o (rlen_rdata)
  );

  llr_ram #(.WIDTH(8), .DEPTH(STACK_DEPTH)) u_stack (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_accept   = in_valid_i && (state_q == ST_IDLE);
  assign out_free    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  assign is_nt     = (stk_rdata inside {[NT_FIRST:NT_LAST]});
  assign rule_idx  = RuleW'(tbl_rdata - 7'd1);
  assign cnt_dec   = count_q - CntW'(1);
  assign fin_state = end_q ? ST_VERDICT : ST_IDLE;

  // Leftover symbols after the end marker reject the string.
  always_comb begin
    if (fail_q != VERDICT_ACCEPT) begin
      end_verdict = fail_q;
    end else if (count_q != '0) begin
      end_verdict = VERDICT_REJECT;
    end else begin
      end_verdict = VERDICT_ACCEPT;
    end
  end

  // Load path: table and rule beats write straight into their memories.
  always_comb begin
    rsym_we    = 1'b0;
    rlen_we    = 1'b0;
    rsym_waddr = RsymAw'(32'(rule_number_i) * RULE_LEN + 32'(rule_slot_i));
    rlen_waddr = RuleW'(rule_number_i);
    if (32'(rule_length_i) > RULE_LEN) begin
      rlen_wdata = LenW'(RULE_LEN);
    end else begin
      rlen_wdata = LenW'(rule_length_i);
    end
    if (in_accept && kind_i == KIND_RULE && 32'(rule_number_i) < RULE_COUNT) begin
      rlen_we = 1'b1;
      rsym_we = (32'(rule_slot_i) < RULE_LEN);
    end
  end

  // Table write port: the clearing sweep after reset, then table beats.
  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = {nonterminal_index_i, table_column_i};
    tbl_wdata = table_rule_i;
    if (state_q == ST_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_q;
      tbl_wdata = '0;
    end else if (in_accept && kind_i == KIND_TABLE &&
                 32'(nonterminal_index_i) < NT_ROWS) begin
      tbl_we = 1'b1;
    end
  end

  // Parse sequencer: next state, stack accesses and read addresses.
  always_comb begin
    state_d     = state_q;
    open_d      = open_q;
    fail_d      = fail_q;
    count_d     = count_q;
    steps_d     = steps_q;
    sym_d       = sym_q;
    end_d       = end_q;
    rbase_d     = rbase_q;
    k_d         = k_q;
    clr_d       = clr_q;
    out_valid_d = out_valid_q && out_stall_i;
    verdict_d   = verdict_q;

    stk_we     = 1'b0;
    stk_waddr  = StkAw'(count_q);
    stk_wdata  = rsym_rdata;
    stk_raddr  = StkAw'(cnt_dec);
    tbl_raddr  = {5'(stk_rdata - NT_FIRST), sym_q};
    rlen_raddr = rule_idx;
    rsym_raddr = rbase_q + RsymAw'(k_q) - RsymAw'(2);

    case (state_q)
      ST_CLEAR: begin
        clr_d = clr_q + TBL_AW'(1);
        if (32'(clr_q) == TBL_DEPTH - 1) begin
          state_d = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_accept && (kind_i == KIND_CHAR || kind_i == KIND_END)) begin
          end_d   = (kind_i == KIND_END);
          sym_d   = (kind_i == KIND_END) ? END_MARK : char_in_i;
          steps_d = '0;
          state_d = open_q ? ST_FETCH : ST_OPEN0;
        end
      end

      // A new string starts with the end marker below the start symbol.
      ST_OPEN0: begin
        stk_we    = 1'b1;
        stk_waddr = StkAw'(0);
        stk_wdata = END_MARK;
        state_d   = ST_OPEN1;
      end

      ST_OPEN1: begin
        stk_we    = 1'b1;
        stk_waddr = StkAw'(1);
        stk_wdata = {1'b0, start_q};
        count_d   = CntW'(2);
        fail_d    = VERDICT_ACCEPT;
        open_d    = 1'b1;
        state_d   = ST_FETCH;
      end

      // Read the stack top, unless the string has already failed or the stack is empty.
      ST_FETCH: begin
        if (fail_q != VERDICT_ACCEPT) begin
          state_d = fin_state;
        end else if (count_q == '0) begin
          fail_d  = VERDICT_REJECT;
          state_d = fin_state;
        end else begin
          state_d = ST_TOP;
        end
      end

      // Match pops; a nonterminal looks up the table; anything else, or too many expansions, rejects.
      ST_TOP: begin
        if (stk_rdata == sym_q) begin
          count_d = cnt_dec;
          state_d = fin_state;
        end else if (!is_nt || 32'(steps_q) >= ExpLimit) begin
          fail_d  = VERDICT_REJECT;
          state_d = fin_state;
        end else begin
          steps_d = steps_q + StepW'(1);
          state_d = ST_CELL;
        end
      end

      // An empty cell or one naming a missing rule rejects.
      ST_CELL: begin
        if (tbl_rdata == '0 || 32'(tbl_rdata) - 1 >= RULE_COUNT) begin
          fail_d  = VERDICT_REJECT;
          state_d = fin_state;
        end else begin
          rbase_d = RsymAw'(32'(rule_idx) * RULE_LEN);
          state_d = ST_LEN;
        end
      end

      // Pop the nonterminal and check room for the right-hand side.
      ST_LEN: begin
        count_d    = cnt_dec;
        rsym_raddr = rbase_q + RsymAw'(rlen_rdata) - RsymAw'(1);
        k_d        = rlen_rdata;
        if (32'(cnt_dec) + 32'(rlen_rdata) > STACK_DEPTH) begin
          fail_d  = VERDICT_OVERFLOW;
          state_d = fin_state;
        end else if (rlen_rdata == '0) begin
          state_d = ST_FETCH;
        end else begin
          state_d = ST_PUSH;
        end
      end

      // Push the right-hand side last symbol first, one symbol a cycle.
      ST_PUSH: begin
        stk_we  = 1'b1;
        count_d = count_q + CntW'(1);
        k_d     = k_q - LenW'(1);
        if (k_q == LenW'(1)) begin
          state_d = ST_FETCH;
        end
      end

      ST_VERDICT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          verdict_d   = end_verdict;
          open_d      = 1'b0;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      open_q      <= 1'b0;
      fail_q      <= VERDICT_ACCEPT;
      count_q     <= '0;
      steps_q     <= '0;
      end_q       <= 1'b0;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      fail_q      <= fail_d;
      count_q     <= count_d;
      steps_q     <= steps_d;
      end_q       <= end_d;
      clr_q       <= clr_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    sym_q     <= sym_d;
    rbase_q   <= rbase_d;
    k_q       <= k_d;
    verdict_q <= verdict_d;
  end

  // Start symbol register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_RESET;
    end else if (cfg_we_i) begin
      start_q <= cfg_wdata_i;
    end
  end

endmodule
